[sv/lbb_pkg.sv]
// ----------------------------------------------------------------------------
// lbb_pkg: shared types and constants of the LED blink/breathe generator
// Widths, reset values, register codes and the structs passed between units.
// ----------------------------------------------------------------------------
package lbb_pkg;

  localparam int LEVEL_BITS   = 10;
  localparam int TIME_BITS    = 16;
  localparam int DIV_BITS     = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;
  localparam int CNT_BITS     = $clog2(DIV_BITS + 1);
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS;

  localparam int LEVEL_MAX = (1 << LEVEL_BITS) - 1;
  localparam int TIME_MAX  = (1 << TIME_BITS) - 1;

  // register reset values
  localparam int LOW_RST        = 0;
  localparam int HIGH_RST       = 1023 & LEVEL_MAX;
  localparam int DELAY_RST      = 200 & TIME_MAX;
  localparam int LONG_RST       = 2000 & TIME_MAX;
  localparam int SHORT_RST      = 500 & TIME_MAX;
  localparam int LONG_PRESS_RST = 500 & TIME_MAX;

  // ramp steps for the reset configuration, one per period choice
  localparam int SPAN_RST       = (HIGH_RST > LOW_RST) ? HIGH_RST - LOW_RST : 0;
  localparam int DELAY_RST_NZ   = (DELAY_RST == 0) ? 1 : DELAY_RST;
  localparam int Q_LONG_RST     = LONG_RST / DELAY_RST_NZ;
  localparam int Q_SHORT_RST    = SHORT_RST / DELAY_RST_NZ;
  localparam int STEP_LONG_RAW  = (Q_LONG_RST == 0) ? SPAN_RST : SPAN_RST / Q_LONG_RST;
  localparam int STEP_SHORT_RAW = (Q_SHORT_RST == 0) ? SPAN_RST : SPAN_RST / Q_SHORT_RST;
  localparam int STEP_LONG_RST  = (STEP_LONG_RAW < 1) ? 1 : STEP_LONG_RAW;
  localparam int STEP_SHORT_RST = (STEP_SHORT_RAW < 1) ? 1 : STEP_SHORT_RAW;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOW_LEVEL     = 3'd0,
    REG_HIGH_LEVEL    = 3'd1,
    REG_STEP_DELAY    = 3'd2,
    REG_LONG_PERIOD   = 3'd3,
    REG_SHORT_PERIOD  = 3'd4,
    REG_LONG_PRESS    = 3'd5,
    REG_BREATHE_MODE  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] low_level;
    logic [LEVEL_BITS-1:0] high_level;
    logic [TIME_BITS-1:0]  step_delay_ms;
    logic [TIME_BITS-1:0]  long_period_ms;
    logic [TIME_BITS-1:0]  short_period_ms;
    logic [TIME_BITS-1:0]  long_press_ms;
    logic                  breathe_mode;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] step_long;
    logic [LEVEL_BITS-1:0] step_short;
  } step_pair_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] duty;
    logic                  release_seen;
    logic                  long_press;
  } result_t;

endpackage

[sv/lbb_divider.sv]
// ----------------------------------------------------------------------------
// lbb_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle, DIV_BITS quotient bits per run.
// ----------------------------------------------------------------------------
module lbb_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lbb_pkg::DIV_BITS-1:0] dividend_i,
  input  logic [lbb_pkg::DIV_BITS-1:0] divisor_i,
  output logic                         done_o,
  output logic [lbb_pkg::DIV_BITS-1:0] quotient_o
);

  localparam int N = lbb_pkg::DIV_BITS;

  logic                              active_q, active_d;
  logic                              done_q, done_d;
  logic [lbb_pkg::CNT_BITS-1:0]      cnt_q, cnt_d;
  logic [N-1:0]                      rem_q, rem_d;
  logic [N-1:0]                      quo_q, quo_d;
  logic [N-1:0]                      dvs_q, dvs_d;
  logic [N:0]                        rem_sh;
  logic [N+1:0]                      diff;

  assign rem_sh = {rem_q, quo_q[N-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dvs_d    = dvs_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = lbb_pkg::CNT_BITS'(N);
      rem_d    = '0;
      quo_d    = dividend_i;
      dvs_d    = divisor_i;
    end else if (active_q) begin
      if (!diff[N+1]) begin
        rem_d = diff[N-1:0];
        quo_d = {quo_q[N-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[N-1:0];
        quo_d = {quo_q[N-2:0], 1'b0};
      end
      cnt_d = cnt_q - lbb_pkg::CNT_BITS'(1);
      if (cnt_q == lbb_pkg::CNT_BITS'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[sv/lbb_step_unit.sv]
// ----------------------------------------------------------------------------
// lbb_step_unit: ramp step sequencer
// Derives the ramp step for both period choices after each register write.
// ----------------------------------------------------------------------------
module lbb_step_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  lbb_pkg::cfg_t       cfg_i,
  output lbb_pkg::step_pair_t steps_o,
  output logic                busy_o
);

  localparam int N = lbb_pkg::DIV_BITS;
  localparam int L = lbb_pkg::LEVEL_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT_Q,
    S_WAIT_S
  } state_e;

  state_e              state_q, state_d;
  logic                sel_q, sel_d;
  lbb_pkg::step_pair_t steps_q, steps_d;

  logic                div_start;
  logic [N-1:0]        div_dividend;
  logic [N-1:0]        div_divisor;
  logic                div_done;
  logic [N-1:0]        div_quotient;

  logic [L-1:0]        span;
  logic [N-1:0]        delay_nz;
  logic [N-1:0]        period_next;
  logic [L-1:0]        step_new;
  logic                store;

  assign span = (cfg_i.high_level > cfg_i.low_level) ?
                cfg_i.high_level - cfg_i.low_level : '0;
  assign delay_nz = (cfg_i.step_delay_ms == '0) ? N'(1) : N'(cfg_i.step_delay_ms);
  assign period_next = N'(cfg_i.short_period_ms);

  lbb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  always_comb begin
    state_d      = state_q;
    sel_d        = sel_q;
    steps_d      = steps_q;
    div_start    = 1'b0;
    div_dividend = N'(cfg_i.long_period_ms);
    div_divisor  = delay_nz;
    store        = 1'b0;
    step_new     = span;

    if (restart_i) begin
      // the written register lands on this edge; S_START starts the divider in the next cycle
      sel_d     = 1'b0;
      state_d   = S_START;
    end else begin
      unique case (state_q)
        S_IDLE: ;
        S_START: begin
          div_start = 1'b1;
          state_d   = S_WAIT_Q;
        end
        S_WAIT_Q: begin
          if (div_done) begin
            if (div_quotient == '0) begin
              store    = 1'b1;
              step_new = span;
            end else begin
              div_start    = 1'b1;
              div_dividend = N'(span);
              div_divisor  = div_quotient;
              state_d      = S_WAIT_S;
            end
          end
        end
        S_WAIT_S: begin
          if (div_done) begin
            store    = 1'b1;
            step_new = div_quotient[L-1:0];
          end
        end
        default: state_d = S_IDLE;
      endcase
    end

    if (store) begin
      // force the step to at least one
      if (step_new == '0) begin
        step_new = L'(1);
      end
      if (!sel_q) begin
        steps_d.step_long = step_new;
        sel_d        = 1'b1;
        div_start    = 1'b1;
        div_dividend = period_next;
        div_divisor  = delay_nz;
        state_d      = S_WAIT_Q;
      end else begin
        steps_d.step_short = step_new;
        state_d            = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      sel_q              <= 1'b0;
      steps_q.step_long  <= L'(lbb_pkg::STEP_LONG_RST);
      steps_q.step_short <= L'(lbb_pkg::STEP_SHORT_RST);
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      steps_q <= steps_d;
    end
  end

  assign steps_o = steps_q;
  assign busy_o  = (state_q != S_IDLE);

endmodule

[sv/lbb_tick.sv]
// ----------------------------------------------------------------------------
// lbb_tick: per-tick datapath
// Button press timing, period toggle, blink phase and breathing ramp.
// ----------------------------------------------------------------------------
module lbb_tick (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic                button_level_i,
  input  lbb_pkg::cfg_t       cfg_i,
  input  lbb_pkg::step_pair_t steps_i,
  output lbb_pkg::result_t    result_o
);

  localparam int L = lbb_pkg::LEVEL_BITS;
  localparam int T = lbb_pkg::TIME_BITS;

  logic [L-1:0] level_q, level_d;
  logic         ramp_down_q, ramp_down_d;
  logic         low_phase_q, low_phase_d;
  logic [T-1:0] hold_q, hold_d;
  logic [T-1:0] press_q, press_d;
  logic         prev_q, prev_d;
  logic         short_q, short_d;

  logic [T-1:0] press_inc;
  logic [L-1:0] step;
  logic [T-1:0] period;
  logic [T-1:0] delay_nz;
  logic [T-1:0] period_nz;
  logic [T-1:0] limit;
  logic [T:0]   hold_inc;
  logic         wrap;
  logic         span_pos;
  logic [L-1:0] lvl_c;
  logic [L:0]   up_sum;
  logic [L:0]   down_lim;

  assign press_inc = (press_q == '1) ? press_q : press_q + T'(1);
  assign span_pos  = cfg_i.high_level > cfg_i.low_level;
  assign delay_nz  = (cfg_i.step_delay_ms == '0) ? T'(1) : cfg_i.step_delay_ms;
  assign hold_inc  = {1'b0, hold_q} + (T+1)'(1);

  always_comb begin
    press_d     = press_q;
    short_d     = short_q;
    prev_d      = button_level_i;
    level_d     = level_q;
    ramp_down_d = ramp_down_q;
    low_phase_d = low_phase_q;
    hold_d      = hold_q;
    result_o    = '0;

    // button: the toggle acts on this same tick
    if (prev_q && !button_level_i) begin
      press_d = '0;
    end else if (!prev_q) begin
      press_d = press_inc;
      if (button_level_i) begin
        result_o.release_seen = 1'b1;
        result_o.long_press   = press_inc > cfg_i.long_press_ms;
        short_d               = !short_q;
      end
    end

    step      = short_d ? steps_i.step_short : steps_i.step_long;
    period    = short_d ? cfg_i.short_period_ms : cfg_i.long_period_ms;
    period_nz = (period == '0) ? T'(1) : period;

    // clamp the level into the current limits
    if (!span_pos) begin
      lvl_c = cfg_i.low_level;
    end else if (level_q < cfg_i.low_level) begin
      lvl_c = cfg_i.low_level;
    end else if (level_q > cfg_i.high_level) begin
      lvl_c = cfg_i.high_level;
    end else begin
      lvl_c = level_q;
    end
    up_sum   = {1'b0, lvl_c} + {1'b0, step};
    down_lim = {1'b0, cfg_i.low_level} + {1'b0, step};

    if (cfg_i.breathe_mode) begin
      limit = delay_nz;
    end else begin
      limit = low_phase_q ? period_nz : delay_nz;
    end
    wrap = hold_inc >= {1'b0, limit};

    if (cfg_i.breathe_mode) begin
      result_o.duty = lvl_c;
      level_d       = lvl_c;
      if (!span_pos) begin
        ramp_down_d = 1'b0;
      end
      if (wrap) begin
        hold_d = '0;
        if (span_pos) begin
          if (!ramp_down_q) begin
            if (up_sum >= {1'b0, cfg_i.high_level}) begin
              level_d     = cfg_i.high_level;
              ramp_down_d = 1'b1;
            end else begin
              level_d = up_sum[L-1:0];
            end
          end else begin
            if ({1'b0, lvl_c} <= down_lim) begin
              level_d     = cfg_i.low_level;
              ramp_down_d = 1'b0;
            end else begin
              level_d = lvl_c - step;
            end
          end
        end
      end else begin
        hold_d = hold_inc[T-1:0];
      end
    end else begin
      result_o.duty = low_phase_q ? cfg_i.low_level : cfg_i.high_level;
      if (wrap) begin
        hold_d      = '0;
        low_phase_d = !low_phase_q;
      end else begin
        hold_d = hold_inc[T-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= L'(lbb_pkg::LOW_RST);
      ramp_down_q <= 1'b0;
      low_phase_q <= 1'b0;
      hold_q      <= '0;
      press_q     <= '0;
      prev_q      <= 1'b1;
      short_q     <= 1'b0;
    end else if (advance_i) begin
      level_q     <= level_d;
      ramp_down_q <= ramp_down_d;
      low_phase_q <= low_phase_d;
      hold_q      <= hold_d;
      press_q     <= press_d;
      prev_q      <= prev_d;
      short_q     <= short_d;
    end
  end

endmodule

[sv/led_blink_breathe_generator_top.sv]
// ----------------------------------------------------------------------------
// led_blink_breathe_generator_top: LED blink / breathe duty generator
// One millisecond tick in, one PWM duty value and a button report out.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat (in_valid_i/in_ready_o) is one millisecond tick carrying
//   the sampled button line. Each tick yields exactly one output beat
//   (out_valid_o/out_ready_i) with the duty level, a release flag and a
//   long-press flag.
//   The tick is captured in an input register and its result is written into
//   the output register when the tick advances. One tick per cycle is
//   sustained while the receiver keeps up and no step derivation runs.
//   Ticks keep entering while a result waits, as long as the datapath can move.
//   If the receiver stalls, the output register holds its beat and the input
//   register fills, then in_ready_o drops until the receiver takes the beat.
//   Registers are written on the cfg channel (index 0..6, others ignored).
//   After a write, the one shared iterative divider derives the ramp step for
//   both the long and short period, and in_ready_o stays low until both steps
//   are stored; the derivation ends early when a quotient comes out zero.
//   Reset loads the register defaults and the matching ramp steps, so ticks
//   are taken right after reset with no warm-up.
// ----------------------------------------------------------------------------
module led_blink_breathe_generator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              button_level_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lbb_pkg::LEVEL_BITS-1:0]    duty_o,
  output logic                              release_seen_o,
  output logic                              long_press_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lbb_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [lbb_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int L = lbb_pkg::LEVEL_BITS;
  localparam int T = lbb_pkg::TIME_BITS;

  lbb_pkg::cfg_t       cfg_q, cfg_d;
  lbb_pkg::step_pair_t steps;
  lbb_pkg::result_t    result;
  lbb_pkg::result_t    out_q;

  logic cfg_write;
  logic restart;
  logic busy;
  logic in_valid_q;
  logic button_q;
  logic out_valid_q;
  logic advance;

  // configuration port: always ready, a write to index 0..6 restarts the step derivation
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_write) begin
      restart = 1'b1;
      unique case (lbb_pkg::cfg_reg_e'(cfg_index_i))
        lbb_pkg::REG_LOW_LEVEL:    cfg_d.low_level       = cfg_data_i[L-1:0];
        lbb_pkg::REG_HIGH_LEVEL:   cfg_d.high_level      = cfg_data_i[L-1:0];
        lbb_pkg::REG_STEP_DELAY:   cfg_d.step_delay_ms   = cfg_data_i[T-1:0];
        lbb_pkg::REG_LONG_PERIOD:  cfg_d.long_period_ms  = cfg_data_i[T-1:0];
        lbb_pkg::REG_SHORT_PERIOD: cfg_d.short_period_ms = cfg_data_i[T-1:0];
        lbb_pkg::REG_LONG_PRESS:   cfg_d.long_press_ms   = cfg_data_i[T-1:0];
        lbb_pkg::REG_BREATHE_MODE: cfg_d.breathe_mode    = cfg_data_i[0];
        default:                   restart               = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_level       <= L'(lbb_pkg::LOW_RST);
      cfg_q.high_level      <= L'(lbb_pkg::HIGH_RST);
      cfg_q.step_delay_ms   <= T'(lbb_pkg::DELAY_RST);
      cfg_q.long_period_ms  <= T'(lbb_pkg::LONG_RST);
      cfg_q.short_period_ms <= T'(lbb_pkg::SHORT_RST);
      cfg_q.long_press_ms   <= T'(lbb_pkg::LONG_PRESS_RST);
      cfg_q.breathe_mode    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lbb_step_unit u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .cfg_i     (cfg_q),
    .steps_o   (steps),
    .busy_o    (busy)
  );

  // advance the held tick whenever the output register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy && (!in_valid_q || advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: capture the tick, hold the result until taken
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      button_q <= button_level_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  lbb_tick u_tick (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .button_level_i (button_q),
    .cfg_i          (cfg_q),
    .steps_i        (steps),
    .result_o       (result)
  );

  assign out_valid_o    = out_valid_q;
  assign duty_o         = out_q.duty;
  assign release_seen_o = out_q.release_seen;
  assign long_press_o   = out_q.long_press;

endmodule
